FILE: rtl/core/e2c_pkg.sv
package e2c_pkg;

    // Field widths
    localparam int IN_W   = 48;
    localparam int YEAR_W = 24;

    // Seconds to days: 86400 = 675 << 7, the low seven bits pass straight through
    localparam int SECS_PER_DAY = 86400;
    localparam int DAY_SHIFT    = 7;
    localparam int DAY_ODD      = SECS_PER_DAY >> DAY_SHIFT;
    localparam int HALF_W       = 21;
    localparam int SPLIT_W      = IN_W - DAY_SHIFT + 1;
    localparam int DAY_BIAS_EXP = 31;

    // Bias that makes the shifted seconds non-negative; a multiple of 675
    localparam logic [SPLIT_W-1:0] SEC_BIAS = SPLIT_W'(DAY_ODD) << DAY_BIAS_EXP;

    // Calendar constants
    localparam int SHIFT_TO_MARCH0   = 719468;
    localparam int DAYS_PER_ERA      = 146097;
    localparam int LAST_DAY_OF_ERA   = 146096;
    localparam int DAYS_PER_CENTURY  = 36524;
    localparam int DAYS_PER_4Y_LESS1 = 1460;
    localparam int DAYS_PER_YEAR     = 365;
    localparam int DAYS_PER_WEEK     = 7;
    localparam int EPOCH_WEEKDAY     = 4;
    localparam int SECS_PER_MIN      = 60;
    localparam int MINS_PER_HOUR     = 60;
    localparam int YEARS_PER_ERA     = 400;
    localparam int YEARS_PER_CENTURY = 100;
    localparam int TM_YEAR_BASE      = 1900;
    localparam int DAYS_JAN_FEB      = 59;

    // Era count is kept biased so that the era division is unsigned
    localparam int ERA_BIAS_EXP   = 14;
    localparam int ERA_COUNT_BIAS = 1 << ERA_BIAS_EXP;

    // Offset from the biased day count to the biased March-based day count
    localparam logic [31:0] DU_OFS = 32'(64'(SHIFT_TO_MARCH0)
        + (64'(DAYS_PER_ERA) << ERA_BIAS_EXP) - (64'd1 << DAY_BIAS_EXP));

    // Offset from the biased day count to a count whose residue mod 7 is the weekday
    localparam logic [31:0] WD_OFS = 32'((64'(EPOCH_WEEKDAY)
        + 64'(DAYS_PER_WEEK - 1) * (64'd1 << DAY_BIAS_EXP)) % 64'(DAYS_PER_WEEK));

    // Estimating reciprocals: quotient is exact or one short, fixed in the next stage
    localparam int EST_K = 32;
    localparam logic [31:0] RCP_DAY_ODD = 32'((64'd1 << EST_K) / 64'(DAY_ODD));
    localparam logic [31:0] RCP_ERA     = 32'((64'd1 << EST_K) / 64'(DAYS_PER_ERA));
    localparam logic [31:0] RCP_WEEK    = 32'((64'd1 << EST_K) / 64'(DAYS_PER_WEEK));

    // Exact reciprocals (rounded up) for narrow dividends
    localparam int MIN_K   = 23;
    localparam int HOUR_K  = 17;
    localparam int C4Y_K   = 29;
    localparam int CENT_K  = 34;
    localparam int YEAR_K  = 27;
    localparam int CENTY_K = 16;
    localparam logic [31:0] RCP_MIN  = 32'(((64'd1 << MIN_K) + 64'(SECS_PER_MIN) - 64'd1)
                                          / 64'(SECS_PER_MIN));
    localparam logic [31:0] RCP_HOUR = 32'(((64'd1 << HOUR_K) + 64'(MINS_PER_HOUR) - 64'd1)
                                          / 64'(MINS_PER_HOUR));
    localparam logic [31:0] RCP_C4Y  = 32'(((64'd1 << C4Y_K) + 64'(DAYS_PER_4Y_LESS1) - 64'd1)
                                          / 64'(DAYS_PER_4Y_LESS1));
    localparam logic [31:0] RCP_CENT = 32'(((64'd1 << CENT_K) + 64'(DAYS_PER_CENTURY) - 64'd1)
                                          / 64'(DAYS_PER_CENTURY));
    localparam logic [31:0] RCP_YEAR = 32'(((64'd1 << YEAR_K) + 64'(DAYS_PER_YEAR) - 64'd1)
                                          / 64'(DAYS_PER_YEAR));
    localparam logic [31:0] RCP_CENTY = 32'(((64'd1 << CENTY_K) + 64'(YEARS_PER_CENTURY)
                                          - 64'd1) / 64'(YEARS_PER_CENTURY));

    // March-based month starts; index 10 is January
    localparam int MONTHS = 12;
    localparam int MP_JAN = 10;
    localparam int MARCH_INDEX = 2;
    localparam logic [8:0] MONTH_START [MONTHS] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    // Pipeline shape
    localparam int SPLIT_STAGES = 5;
    localparam int CIVIL_STAGES = 6;
    localparam int NUM_STAGES   = SPLIT_STAGES + CIVIL_STAGES;

    typedef struct packed {
        logic [CIVIL_STAGES-1:0] civil;
        logic [SPLIT_STAGES-1:0] split;
    } t_pipe_en;

    typedef struct packed {
        logic [31:0] q;
        logic [31:0] r;
    } t_quot_rem;

    // Quotient by reciprocal multiply and shift
    function automatic logic [31:0] f_div_est(input logic [31:0] x, input logic [31:0] m,
                                              input int k);
        logic [63:0] prod;
        prod = 64'(x) * 64'(m);
        return 32'(prod >> k);
    endfunction

    // Remainder from an estimate that may be one short, with one correction step
    function automatic t_quot_rem f_div_fix(input logic [31:0] x, input logic [31:0] qe,
                                            input logic [31:0] d);
        logic [63:0] prod;
        logic [31:0] rem;
        t_quot_rem   res;
        prod = 64'(qe) * 64'(d);
        rem  = x - prod[31:0];
        if (rem >= d) begin
            res.q = qe + 32'd1;
            res.r = rem - d;
        end else begin
            res.q = qe;
            res.r = rem;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/e2c_flow.sv
module e2c_flow
    import e2c_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_pipe_en o_en
);

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] n_v;
    logic [NUM_STAGES-1:0] w_ready;

    // A stage loads when the output is not stalled or it or some stage ahead of it is empty
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ready
        assign w_ready[k] = !i_out_stall || !(&r_v[NUM_STAGES-1:k]);
    end

    // Advance valid bits, hold those that cannot move
    assign n_v = (w_ready & {r_v[NUM_STAGES-2:0], i_in_valid}) | (~w_ready & r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_stall  = !w_ready[0];
    assign o_out_valid = r_v[NUM_STAGES-1];
    assign o_en.split  = w_ready[SPLIT_STAGES-1:0];
    assign o_en.civil  = w_ready[NUM_STAGES-1:SPLIT_STAGES];

    // Accepted transaction lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v[0])
        else $error("accepted transaction missing from first stage");

    // A blocked first stage keeps its transaction
    a_first_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !w_ready[1]) |=> r_v[0])
        else $error("blocked transaction dropped from first stage");

    // An empty pipeline never pushes back
    a_empty_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v == '0) |-> !o_in_stall)
        else $error("stall raised with empty pipeline");

    // A full pipeline with a stalled result pushes back
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && i_out_stall) |-> o_in_stall)
        else $error("full pipeline accepted a transaction");

endmodule

FILE: rtl/core/e2c_day_split.sv
module e2c_day_split
    import e2c_pkg::*;
(
    input  logic                    i_clk,
    input  logic [SPLIT_STAGES-1:0] i_en,
    input  logic signed [IN_W-1:0]  i_epoch_seconds,
    output logic [31:0]             o_days_u,
    output logic [16:0]             o_tod
);

    logic [IN_W-1:0]    r_s1_secs;
    logic [SPLIT_W-1:0] w_u;
    logic [31:0]        n_s2_qe;
    logic [HALF_W-1:0]  r_s2_uh;
    logic [HALF_W-1:0]  r_s2_ul;
    logic [HALF_W-1:0]  r_s2_qe;
    logic [DAY_SHIFT-1:0] r_s2_low;
    t_quot_rem          w_fh;
    logic [11:0]        r_s3_qh;
    logic [30:0]        r_s3_x2;
    logic [DAY_SHIFT-1:0] r_s3_low;
    logic [31:0]        n_s4_qe;
    logic [11:0]        r_s4_qh;
    logic [30:0]        r_s4_x2;
    logic [HALF_W-1:0]  r_s4_qe;
    logic [DAY_SHIFT-1:0] r_s4_low;
    t_quot_rem          w_fl;
    logic [32:0]        w_days;
    logic [31:0]        r_s5_days_u;
    logic [16:0]        r_s5_tod;

    // Input register
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_secs <= i_epoch_seconds;
        end
    end

    // Drop the low seven bits, bias to non-negative, estimate the high digit over 675
    assign w_u     = {r_s1_secs[IN_W-1], r_s1_secs[IN_W-1:DAY_SHIFT]} + SEC_BIAS;
    assign n_s2_qe = f_div_est(32'(w_u[SPLIT_W-1:HALF_W]), RCP_DAY_ODD, EST_K);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s2_uh  <= w_u[SPLIT_W-1:HALF_W];
            r_s2_ul  <= w_u[HALF_W-1:0];
            r_s2_qe  <= n_s2_qe[HALF_W-1:0];
            r_s2_low <= r_s1_secs[DAY_SHIFT-1:0];
        end
    end

    // Fix the high digit, carry its remainder into the low dividend
    assign w_fh = f_div_fix(32'(r_s2_uh), 32'(r_s2_qe), 32'(DAY_ODD));

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s3_qh  <= w_fh.q[11:0];
            r_s3_x2  <= {w_fh.r[9:0], r_s2_ul};
            r_s3_low <= r_s2_low;
        end
    end

    // Estimate the low digit
    assign n_s4_qe = f_div_est(32'(r_s3_x2), RCP_DAY_ODD, EST_K);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s4_qh  <= r_s3_qh;
            r_s4_x2  <= r_s3_x2;
            r_s4_qe  <= n_s4_qe[HALF_W-1:0];
            r_s4_low <= r_s3_low;
        end
    end

    // Fix the low digit; join digits into the biased day count and rebuild time of day
    assign w_fl   = f_div_fix(32'(r_s4_x2), 32'(r_s4_qe), 32'(DAY_ODD));
    assign w_days = {r_s4_qh, w_fl.q[HALF_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s5_days_u <= w_days[31:0];
            r_s5_tod    <= {w_fl.r[9:0], r_s4_low};
        end
    end

    assign o_days_u = r_s5_days_u;
    assign o_tod    = r_s5_tod;

endmodule

FILE: rtl/core/e2c_civil.sv
module e2c_civil
    import e2c_pkg::*;
(
    input  logic                     i_clk,
    input  logic [CIVIL_STAGES-1:0]  i_en,
    input  logic [31:0]              i_days_u,
    input  logic [16:0]              i_tod,
    output logic signed [YEAR_W-1:0] o_years_since_1900,
    output logic [3:0]               o_month_index,
    output logic [4:0]               o_day_of_month,
    output logic [2:0]               o_weekday,
    output logic [8:0]               o_day_of_year,
    output logic [4:0]               o_hour,
    output logic [5:0]               o_minute,
    output logic [5:0]               o_second
);

    // Stage 6
    logic [31:0] w_du;
    logic [31:0] w_wdx;
    logic [31:0] n_s6_era_e;
    logic [31:0] n_s6_wd_e;
    logic [31:0] n_s6_mall;
    logic [31:0] r_s6_du;
    logic [14:0] r_s6_era_e;
    logic [31:0] r_s6_wdx;
    logic [29:0] r_s6_wd_e;
    logic [16:0] r_s6_tod;
    logic [10:0] r_s6_mall;
    // Stage 7
    t_quot_rem   w_fe;
    t_quot_rem   w_fw;
    logic [16:0] w_sec;
    logic [31:0] n_s7_hour;
    logic [14:0] r_s7_era_u;
    logic [17:0] r_s7_doe;
    logic [2:0]  r_s7_wd;
    logic [5:0]  r_s7_sec;
    logic [4:0]  r_s7_hour;
    logic [10:0] r_s7_mall;
    // Stage 8
    logic [31:0] w_q1460;
    logic [31:0] w_q36524;
    logic [17:0] n_s8_num;
    logic [10:0] w_min;
    logic [17:0] r_s8_num;
    logic [17:0] r_s8_doe;
    logic [14:0] r_s8_era_u;
    logic [2:0]  r_s8_wd;
    logic [5:0]  r_s8_sec;
    logic [4:0]  r_s8_hour;
    logic [5:0]  r_s8_min;
    // Stage 9
    logic [31:0]              n_s9_yoe;
    logic signed [15:0]       w_era;
    logic signed [YEAR_W-1:0] n_s9_ybase;
    logic [8:0]               r_s9_yoe;
    logic [17:0]              r_s9_doe;
    logic signed [YEAR_W-1:0] r_s9_ybase;
    logic [2:0]               r_s9_wd;
    logic [5:0]               r_s9_sec;
    logic [4:0]               r_s9_hour;
    logic [5:0]               r_s9_min;
    // Stage 10
    logic [31:0]              w_cent;
    logic [17:0]              w_mbase;
    logic [17:0]              n_s10_mdoy;
    logic                     n_s10_leap;
    logic [8:0]               r_s10_mdoy;
    logic                     r_s10_leap;
    logic signed [YEAR_W-1:0] r_s10_year;
    logic [2:0]               r_s10_wd;
    logic [5:0]               r_s10_sec;
    logic [4:0]               r_s10_hour;
    logic [5:0]               r_s10_min;
    // Stage 11
    logic [3:0]               w_mp;
    logic [8:0]               w_start;
    logic [8:0]               w_mday;
    logic [3:0]               n_month;
    logic [8:0]               n_yday;
    logic signed [YEAR_W-1:0] n_year;
    logic signed [YEAR_W-1:0] r_year;
    logic [3:0]               r_month;
    logic [4:0]               r_mday;
    logic [2:0]               r_wd;
    logic [8:0]               r_yday;
    logic [4:0]               r_hour;
    logic [5:0]               r_min;
    logic [5:0]               r_sec;

    // Bias the days for the era split and the weekday; estimate minutes of the day
    assign w_du       = i_days_u + DU_OFS;
    assign w_wdx      = i_days_u + WD_OFS;
    assign n_s6_era_e = f_div_est(w_du, RCP_ERA, EST_K);
    assign n_s6_wd_e  = f_div_est(w_wdx, RCP_WEEK, EST_K);
    assign n_s6_mall  = f_div_est(32'(i_tod), RCP_MIN, MIN_K);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s6_du    <= w_du;
            r_s6_era_e <= n_s6_era_e[14:0];
            r_s6_wdx   <= w_wdx;
            r_s6_wd_e  <= n_s6_wd_e[29:0];
            r_s6_tod   <= i_tod;
            r_s6_mall  <= n_s6_mall[10:0];
        end
    end

    // Fix era and weekday; split seconds off; estimate the hour
    assign w_fe      = f_div_fix(r_s6_du, 32'(r_s6_era_e), 32'(DAYS_PER_ERA));
    assign w_fw      = f_div_fix(r_s6_wdx, 32'(r_s6_wd_e), 32'(DAYS_PER_WEEK));
    assign w_sec     = r_s6_tod - 17'(r_s6_mall) * 17'(SECS_PER_MIN);
    assign n_s7_hour = f_div_est(32'(r_s6_mall), RCP_HOUR, HOUR_K);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s7_era_u <= w_fe.q[14:0];
            r_s7_doe   <= w_fe.r[17:0];
            r_s7_wd    <= w_fw.r[2:0];
            r_s7_sec   <= w_sec[5:0];
            r_s7_hour  <= n_s7_hour[4:0];
            r_s7_mall  <= r_s6_mall;
        end
    end

    // Leap-day corrected day count of the era; split minutes off
    assign w_q1460  = f_div_est(32'(r_s7_doe), RCP_C4Y, C4Y_K);
    assign w_q36524 = f_div_est(32'(r_s7_doe), RCP_CENT, CENT_K);
    assign n_s8_num = r_s7_doe - 18'(w_q1460[6:0]) + 18'(w_q36524[2:0])
                    - 18'(r_s7_doe == 18'(LAST_DAY_OF_ERA));
    assign w_min    = r_s7_mall - 11'(r_s7_hour) * 11'(MINS_PER_HOUR);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s8_num   <= n_s8_num;
            r_s8_doe   <= r_s7_doe;
            r_s8_era_u <= r_s7_era_u;
            r_s8_wd    <= r_s7_wd;
            r_s8_sec   <= r_s7_sec;
            r_s8_hour  <= r_s7_hour;
            r_s8_min   <= w_min[5:0];
        end
    end

    // Year of era; year base from the era
    assign n_s9_yoe   = f_div_est(32'(r_s8_num), RCP_YEAR, YEAR_K);
    assign w_era      = 16'({1'b0, r_s8_era_u}) - 16'(ERA_COUNT_BIAS);
    assign n_s9_ybase = YEAR_W'(w_era) * YEAR_W'(YEARS_PER_ERA) - YEAR_W'(TM_YEAR_BASE);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s9_yoe   <= n_s9_yoe[8:0];
            r_s9_doe   <= r_s8_doe;
            r_s9_ybase <= n_s9_ybase;
            r_s9_wd    <= r_s8_wd;
            r_s9_sec   <= r_s8_sec;
            r_s9_hour  <= r_s8_hour;
            r_s9_min   <= r_s8_min;
        end
    end

    // March-based day of year and leap flag of the March year
    assign w_cent     = f_div_est(32'(r_s9_yoe), RCP_CENTY, CENTY_K);
    assign w_mbase    = 18'(r_s9_yoe) * 18'(DAYS_PER_YEAR) + 18'(r_s9_yoe >> 2)
                      - 18'(w_cent[2:0]);
    assign n_s10_mdoy = r_s9_doe - w_mbase;
    assign n_s10_leap = (r_s9_yoe[1:0] == 2'b00)
                     && (r_s9_yoe != 9'(YEARS_PER_CENTURY))
                     && (r_s9_yoe != 9'(2 * YEARS_PER_CENTURY))
                     && (r_s9_yoe != 9'(3 * YEARS_PER_CENTURY));

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s10_mdoy <= n_s10_mdoy[8:0];
            r_s10_leap <= n_s10_leap;
            r_s10_year <= r_s9_ybase + YEAR_W'(r_s9_yoe);
            r_s10_wd   <= r_s9_wd;
            r_s10_sec  <= r_s9_sec;
            r_s10_hour <= r_s9_hour;
            r_s10_min  <= r_s9_min;
        end
    end

    // Find the March-based month by its start day
    always_comb begin
        w_mp = '0;
        for (int i = 0; i < MONTHS; i++) begin
            if (r_s10_mdoy >= MONTH_START[i]) begin
                w_mp = 4'(i);
            end
        end
    end

    assign w_start = MONTH_START[w_mp];
    assign w_mday  = r_s10_mdoy - w_start + 9'd1;
    assign n_month = (w_mp < 4'(MP_JAN)) ? w_mp + 4'(MARCH_INDEX) : w_mp - 4'(MP_JAN);
    assign n_year  = r_s10_year + YEAR_W'(w_mp >= 4'(MP_JAN));
    assign n_yday  = (r_s10_mdoy >= MONTH_START[MP_JAN])
                   ? r_s10_mdoy - MONTH_START[MP_JAN]
                   : r_s10_mdoy + 9'(DAYS_JAN_FEB) + 9'(r_s10_leap);

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_year  <= n_year;
            r_month <= n_month;
            r_mday  <= w_mday[4:0];
            r_wd    <= r_s10_wd;
            r_yday  <= n_yday;
            r_hour  <= r_s10_hour;
            r_min   <= r_s10_min;
            r_sec   <= r_s10_sec;
        end
    end

    assign o_years_since_1900 = r_year;
    assign o_month_index      = r_month;
    assign o_day_of_month     = r_mday;
    assign o_weekday          = r_wd;
    assign o_day_of_year      = r_yday;
    assign o_hour             = r_hour;
    assign o_minute           = r_min;
    assign o_second           = r_sec;

endmodule

FILE: rtl/core/epoch_seconds_to_calendar.sv
// Channel  Valid        Stall         Payload
// -------  -----------  ------------  ------------------------------------------------
// in       i_in_valid   o_in_stall    i_epoch_seconds
// out      o_out_valid  i_out_stall   o_years_since_1900, o_month_index, o_day_of_month,
//                                     o_weekday, o_day_of_year, o_hour, o_minute, o_second
//
// One transaction per cycle sustained while the output is not stalled; a result passes
// through every stage and is presented from the result register of the last one.
// Latency is set by the chain of constant divisions (day split, era split, year of era),
// at most one multiply deep per stage across an eleven-stage pipeline.
// Synchronous active-low reset clears only the stage valid bits.
// A stalled result holds in the output register; earlier stages keep filling bubbles,
// and the input stalls only once every stage is occupied.
module epoch_seconds_to_calendar
    import e2c_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [IN_W-1:0]   i_epoch_seconds,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [YEAR_W-1:0] o_years_since_1900,
    output logic [3:0]               o_month_index,
    output logic [4:0]               o_day_of_month,
    output logic [2:0]               o_weekday,
    output logic [8:0]               o_day_of_year,
    output logic [4:0]               o_hour,
    output logic [5:0]               o_minute,
    output logic [5:0]               o_second
);

    t_pipe_en    w_en;
    logic [31:0] w_days_u;
    logic [16:0] w_tod;

    // Stage valid bits and load enables
    e2c_flow u_flow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_en        (w_en)
    );

    // Seconds to biased day count and time of day
    e2c_day_split u_day_split (
        .i_clk           (i_clk),
        .i_en            (w_en.split),
        .i_epoch_seconds (i_epoch_seconds),
        .o_days_u        (w_days_u),
        .o_tod           (w_tod)
    );

    // Day count to calendar fields
    e2c_civil u_civil (
        .i_clk              (i_clk),
        .i_en               (w_en.civil),
        .i_days_u           (w_days_u),
        .i_tod              (w_tod),
        .o_years_since_1900 (o_years_since_1900),
        .o_month_index      (o_month_index),
        .o_day_of_month     (o_day_of_month),
        .o_weekday          (o_weekday),
        .o_day_of_year      (o_day_of_year),
        .o_hour             (o_hour),
        .o_minute           (o_minute),
        .o_second           (o_second)
    );

endmodule
